>>> hdl/cpa_pkg.sv
// Shared types and codes for the color palette allocator.
// Used by cpa_ram users and the top level; no dependencies.
`default_nettype none

package cpa_pkg;

  localparam logic [2:0] CMD_FIND    = 3'd0;
  localparam logic [2:0] CMD_NEAREST = 3'd1;
  localparam logic [2:0] CMD_ALLOC   = 3'd2;
  localparam logic [2:0] CMD_SET     = 3'd3;
  localparam logic [2:0] CMD_RESIZE  = 3'd4;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RESV  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam int unsigned DIST_W = 18;
  localparam logic [DIST_W-1:0] NEAR_LIMIT = 18'd200000;

  typedef struct packed {
    logic [1:0]  state;
    logic [7:0]  ctx;
    logic [31:0] color;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> hdl/cpa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module cpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(DEPTH)-1:0]       addr_i,
  input  wire logic [WIDTH-1:0]               wdata_i,
  output logic      [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/color_palette_allocator_unit.sv
// Color palette allocator: palette store, sequencer and nearest-color scan.
// Depends on cpa_pkg and cpa_ram.
//
// Usage: requests enter on the in_valid_i/in_ready_o channel, one result per
// request leaves on out_valid_o/out_ready_i. in_ready_o is high only while the
// sequencer is idle; one request is worked on at a time. The palette lives in
// one single-port RAM, so every step reads or writes one entry per cycle.
// Find, find-nearest and allocate walk entries 0 .. entries_in_use-1 through
// a three-stage read / square / compare pipe; an empty palette skips the
// walk. Set entry and resize free every entry they add, one per cycle.
// Rejected requests and resizes that add nothing go straight to the response.
// A finished result sits in the output register; the next request is accepted
// while it waits, but that request completes only once the register is taken.
// The user writes max_size (cfg_we_i/cfg_wdata_i) only while idle; unenforced.
// Reset: palette empty (entries_in_use 0), max_size 256, no result pending.
// No clearing pass is needed: entries only become visible by growth, which
// frees them first.
`default_nettype none

module color_palette_allocator_unit
  import cpa_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [8:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [31:0]       color_value_i,
  input  wire logic              reserved_flag_i,
  input  wire logic [7:0]        context_tag_i,
  input  wire logic [7:0]        entry_index_i,
  input  wire logic [8:0]        new_count_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [8:0]      result_index_o,
  output logic [1:0]             status_o,
  output logic [8:0]             entries_in_use_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;
  localparam logic [LW-1:0] DEPTH_L = LW'(PALETTE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [2:0]        state_q, state_d;
  logic [8:0]        max_size_q;
  logic [LW-1:0]     size_q, size_d;
  logic [LW-1:0]     ptr_q, ptr_d;
  logic [LW-1:0]     tgt_q, tgt_d;
  logic [2:0]        cmd_q;
  logic [31:0]       color_q;
  logic              resv_q;
  logic [7:0]        ctx_q;
  logic [LW-1:0]     res_q, res_d;
  logic [1:0]        stat_q, stat_d;

  logic              exact_found_q, exact_found_d;
  logic [LW-1:0]     exact_idx_q, exact_idx_d;
  logic              free_found_q, free_found_d;
  logic [LW-1:0]     free_idx_q, free_idx_d;
  logic              near_found_q, near_found_d;
  logic [LW-1:0]     near_idx_q, near_idx_d;
  logic [DIST_W-1:0] best_q, best_d;

  logic              rd_v_q;
  logic [LW-1:0]     rd_idx_q;
  logic              sq_v_q;
  logic              sq_alloc_q;
  logic [LW-1:0]     sq_idx_q;
  logic [15:0]       sq_r_q, sq_g_q, sq_b_q;

  logic              out_valid_q;
  logic [8:0]        out_idx_q;
  logic [1:0]        out_stat_q;
  logic [8:0]        out_size_q;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [LW-1:0]     max_ext, lim;
  logic [LW-1:0]     eidx_in, ncount_in;
  entry_t            rd_ent;
  logic              rd_alloc;
  logic [7:0]        dr, dg, db;
  logic [DIST_W-1:0] sq_dist;
  entry_t            new_ent;
  logic              in_acc, out_free;

  cpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign max_ext   = LW'(max_size_q);
  assign lim       = (max_ext > DEPTH_L) ? DEPTH_L : max_ext;
  assign eidx_in   = LW'(entry_index_i);
  assign ncount_in = LW'(new_count_i);

  assign rd_ent   = entry_t'(ram_rdata);
  assign rd_alloc = (rd_ent.state == ST_ALLOC);
  assign dr = abs_diff(rd_ent.color[23:16], color_q[23:16]);
  assign dg = abs_diff(rd_ent.color[15:8],  color_q[15:8]);
  assign db = abs_diff(rd_ent.color[7:0],   color_q[7:0]);
  assign sq_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  assign new_ent.state = resv_q ? ST_RESV : ST_ALLOC;
  assign new_ent.ctx   = ctx_q;
  assign new_ent.color = color_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    size_d        = size_q;
    ptr_d         = ptr_q;
    tgt_d         = tgt_q;
    res_d         = res_q;
    stat_d        = stat_q;
    exact_found_d = exact_found_q;
    exact_idx_d   = exact_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    near_found_d  = near_found_q;
    near_idx_d    = near_idx_q;
    best_d        = best_q;
    ram_we        = 1'b0;
    ram_addr      = ptr_q[AW-1:0];
    ram_wdata     = new_ent;

    // scan pipe, read stage
    if (rd_v_q && rd_alloc && !exact_found_q && (rd_ent.color == color_q)) begin
      exact_found_d = 1'b1;
      exact_idx_d   = rd_idx_q;
    end
    if (rd_v_q && (rd_ent.state == ST_FREE) && !free_found_q) begin
      free_found_d = 1'b1;
      free_idx_d   = rd_idx_q;
    end
    // scan pipe, compare stage
    if (sq_v_q && sq_alloc_q && (sq_dist < best_q)) begin
      best_d       = sq_dist;
      near_found_d = 1'b1;
      near_idx_d   = sq_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          exact_found_d = 1'b0;
          free_found_d  = 1'b0;
          near_found_d  = 1'b0;
          best_d        = NEAR_LIMIT;
          res_d         = '1;
          stat_d        = STAT_RANGE;
          state_d       = S_RESP;
          unique case (command_i)
            CMD_FIND, CMD_NEAREST, CMD_ALLOC: begin
              ptr_d   = '0;
              state_d = (size_q == '0) ? S_DECIDE : S_SCAN;
            end
            CMD_SET: begin
              if (eidx_in < lim) begin
                res_d   = eidx_in;
                stat_d  = STAT_OK;
                tgt_d   = eidx_in;
                state_d = S_CLEAR;
                if (eidx_in >= size_q) begin
                  ptr_d  = size_q;
                  size_d = eidx_in + LW'(1);
                end else begin
                  ptr_d = eidx_in;
                end
              end
            end
            CMD_RESIZE: begin
              if (ncount_in <= lim) begin
                stat_d = STAT_OK;
                size_d = ncount_in;
                if (ncount_in > size_q) begin
                  ptr_d   = size_q;
                  tgt_d   = ncount_in;
                  state_d = S_CLEAR;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_q == size_q - LW'(1)) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q + LW'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !sq_v_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_RESP;
        res_d   = '1;
        stat_d  = STAT_MISS;
        if (exact_found_q) begin
          res_d  = exact_idx_q;
          stat_d = STAT_OK;
        end else if (cmd_q == CMD_NEAREST) begin
          if (near_found_q) begin
            res_d  = near_idx_q;
            stat_d = STAT_OK;
          end
        end else if (cmd_q == CMD_ALLOC) begin
          if (free_found_q) begin
            res_d    = free_idx_q;
            stat_d   = STAT_OK;
            ram_we   = 1'b1;
            ram_addr = free_idx_q[AW-1:0];
          end else if (size_q < lim) begin
            res_d    = size_q;
            stat_d   = STAT_OK;
            size_d   = size_q + LW'(1);
            ram_we   = 1'b1;
            ram_addr = size_q[AW-1:0];
          end
        end
      end
      S_CLEAR: begin
        if (ptr_q == tgt_q) begin
          state_d = S_RESP;
          ram_we  = (cmd_q == CMD_SET);
        end else begin
          ram_we          = 1'b1;
          ram_wdata.state = ST_FREE;
          ram_wdata.ctx   = '0;
          ram_wdata.color = '0;
          ptr_d           = ptr_q + LW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      max_size_q    <= 9'd256;
      size_q        <= '0;
      exact_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      near_found_q  <= 1'b0;
      rd_v_q        <= 1'b0;
      sq_v_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      size_q        <= size_d;
      exact_found_q <= exact_found_d;
      free_found_q  <= free_found_d;
      near_found_q  <= near_found_d;
      rd_v_q        <= (state_q == S_SCAN);
      sq_v_q        <= rd_v_q;
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    tgt_q       <= tgt_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    exact_idx_q <= exact_idx_d;
    free_idx_q  <= free_idx_d;
    near_idx_q  <= near_idx_d;
    best_q      <= best_d;
    rd_idx_q    <= ptr_q;
    sq_idx_q    <= rd_idx_q;
    sq_alloc_q  <= rd_alloc;
    sq_r_q      <= {8'd0, dr} * {8'd0, dr};
    sq_g_q      <= {8'd0, dg} * {8'd0, dg};
    sq_b_q      <= {8'd0, db} * {8'd0, db};
    if (in_acc) begin
      cmd_q   <= command_i;
      color_q <= color_value_i;
      resv_q  <= reserved_flag_i;
      ctx_q   <= context_tag_i;
    end
    if (state_q == S_RESP && out_free) begin
      out_idx_q  <= res_q[8:0];
      out_stat_q <= stat_q;
      out_size_q <= size_q[8:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_index_o   = out_idx_q;
  assign status_o         = out_stat_q;
  assign entries_in_use_o = out_size_q;

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= DEPTH_L)
    else $error("palette size beyond depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> ptr_q < size_q)
    else $error("scan address beyond palette size");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_DECIDE))
    else $error("palette write outside clear or decide");

  a_near_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    near_found_q |-> best_q < NEAR_LIMIT)
    else $error("nearest hit without distance below limit");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for color_palette_allocator_unit: directed and random palette requests
// are checked against a cycle-free palette predictor. Depends on cpa_pkg and the
// RTL under hdl/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpa_pkg::*;

  localparam int DEPTH = 256;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [8:0] index;
    logic [1:0] status;
    logic [8:0] in_use;
  } palette_result_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = CMD_FIND;
  logic [31:0] color_value_i = '0;
  logic        reserved_flag_i = 1'b0;
  logic [7:0]  context_tag_i = '0;
  logic [7:0]  entry_index_i = '0;
  logic [8:0]  new_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [8:0] result_index_o;
  logic [1:0]  status_o;
  logic [8:0]  entries_in_use_o;

  color_palette_allocator_unit #(.PALETTE_DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .color_value_i, .reserved_flag_i,
    .context_tag_i, .entry_index_i, .new_count_i,
    .out_valid_o, .out_ready_i, .result_index_o, .status_o, .entries_in_use_o
  );

  // palette predictor state
  logic [31:0] pal_color [DEPTH];
  logic [1:0]  pal_state [DEPTH];
  int          pal_size;
  logic [8:0]  pal_max;

  logic [31:0] color_pool [16];
  int          pool_wr;

  palette_result_t expected_results [$];
  bit          failed = 1'b0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  rx_mode_e    rx_mode = RX_STEADY;
  int          rx_mode_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #25ms;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int palette_limit();
    return (pal_max > DEPTH) ? DEPTH : int'(pal_max);
  endfunction

  function automatic int find_exact(logic [31:0] color);
    int i;
    for (i = 0; i < pal_size; i++)
      if (pal_state[i] == ST_ALLOC && pal_color[i] == color) return i;
    return -1;
  endfunction

  function automatic int find_nearest(logic [31:0] color);
    int i, best, hit, d, k, a, b;
    best = 200000;
    hit = -1;
    for (i = 0; i < pal_size; i++) begin
      if (pal_state[i] != ST_ALLOC) continue;
      d = 0;
      for (k = 0; k < 3; k++) begin
        a = int'(color[8*k +: 8]);
        b = int'(pal_color[i][8*k +: 8]);
        d += (a - b) * (a - b);
      end
      if (d < best) begin
        best = d;
        hit = i;
      end
    end
    return hit;
  endfunction

  function automatic void grow_palette(int n);
    int i;
    for (i = pal_size; i < n; i++) pal_state[i] = ST_FREE;
    pal_size = n;
  endfunction

  function automatic void store_entry(int i, logic [31:0] color, logic resv);
    pal_color[i] = color;
    pal_state[i] = resv ? ST_RESV : ST_ALLOC;
    color_pool[pool_wr] = color;
    pool_wr = (pool_wr + 1) % 16;
  endfunction

  function automatic palette_result_t apply_request(logic [2:0] cmd, logic [31:0] color,
                                                    logic resv, logic [7:0] eidx,
                                                    logic [8:0] ncount);
    palette_result_t r;
    int lim, hit, i;
    lim = palette_limit();
    r.index = '1;
    r.status = STAT_RANGE;
    case (cmd)
      CMD_FIND, CMD_NEAREST: begin
        hit = find_exact(color);
        if (hit < 0 && cmd == CMD_NEAREST) hit = find_nearest(color);
        if (hit >= 0) begin
          r.index = 9'(hit);
          r.status = STAT_OK;
        end else begin
          r.status = STAT_MISS;
        end
      end
      CMD_ALLOC: begin
        hit = find_exact(color);
        if (hit < 0) begin
          for (i = 0; i < pal_size; i++)
            if (pal_state[i] == ST_FREE) begin
              hit = i;
              break;
            end
          if (hit < 0 && pal_size < lim) begin
            hit = pal_size;
            grow_palette(pal_size + 1);
          end
          if (hit >= 0) store_entry(hit, color, resv);
        end
        if (hit >= 0) begin
          r.index = 9'(hit);
          r.status = STAT_OK;
        end else begin
          r.status = STAT_MISS;
        end
      end
      CMD_SET: begin
        if (int'(eidx) < lim) begin
          if (int'(eidx) >= pal_size) grow_palette(int'(eidx) + 1);
          store_entry(int'(eidx), color, resv);
          r.index = {1'b0, eidx};
          r.status = STAT_OK;
        end
      end
      CMD_RESIZE: begin
        if (int'(ncount) <= lim) begin
          grow_palette(int'(ncount));
          r.status = STAT_OK;
        end
      end
      default: ;
    endcase
    r.in_use = 9'(pal_size);
    return r;
  endfunction

  task automatic send_request(logic [2:0] cmd, logic [31:0] color, logic resv,
                              logic [7:0] ctx, logic [7:0] eidx, logic [8:0] ncount);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    command_i = cmd;
    color_value_i = color;
    reserved_flag_i = resv;
    context_tag_i = ctx;
    entry_index_i = eidx;
    new_count_i = ncount;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(apply_request(cmd, color, resv, eidx, ncount));
  endtask

  task automatic wait_palette_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_max_size(logic [8:0] value);
    wait_palette_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pal_max = value;
  endtask

  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    c = color_pool[$urandom_range(0, 15)];
    case ($urandom_range(0, 4))
      0: ;
      1: c[31:24] = ~c[31:24];
      2: c = $urandom & 32'hFFE0E0E0;
      3: c = c ^ (32'h1 << $urandom_range(0, 23));
      default: c = $urandom;
    endcase
    return c;
  endfunction

  task automatic random_request();
    logic [2:0] cmd;
    logic [7:0] eidx;
    logic [8:0] ncount;
    int lim, r, top;
    lim = palette_limit();
    r = $urandom_range(0, 99);
    if (r < 20) cmd = CMD_FIND;
    else if (r < 40) cmd = CMD_NEAREST;
    else if (r < 65) cmd = CMD_ALLOC;
    else if (r < 82) cmd = CMD_SET;
    else if (r < 96) cmd = CMD_RESIZE;
    else cmd = 3'($urandom_range(int'(CMD_RESIZE) + 1, 7));
    top = (pal_size + 3 > lim - 1) ? lim - 1 : pal_size + 3;
    if (lim == 0 || $urandom_range(0, 5) == 0) eidx = 8'($urandom);
    else eidx = 8'($urandom_range(0, top));
    case ($urandom_range(0, 7))
      0: ncount = 9'($urandom_range(0, DEPTH));
      1: ncount = (lim < DEPTH) ? 9'(lim + 1) : 9'(DEPTH);
      2: ncount = 9'(lim);
      default: begin
        top = (pal_size + 4 > lim) ? lim : pal_size + 4;
        ncount = 9'($urandom_range(0, top));
      end
    endcase
    send_request(cmd, pick_color(), $urandom_range(0, 3) == 0, 8'($urandom), eidx, ncount);
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_STEADY: out_ready_i = 1'b1;
        RX_COIN:   out_ready_i = 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i = ($urandom_range(0, 3) == 0);
        default:   out_ready_i = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    palette_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: index %0d status %0d", result_index_o, status_o);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (result_index_o !== want.index) begin
          $error("result_index: expected %0d, got %0d", $signed(want.index), result_index_o);
          failed = 1'b1;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          failed = 1'b1;
        end
        if (entries_in_use_o !== want.in_use) begin
          $error("entries_in_use: expected %0d, got %0d", want.in_use, entries_in_use_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_empty_palette();
    send_request(CMD_FIND, 32'h0000_0000, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_NEAREST, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 9'd256);
    send_request(3'd5, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 9'd255);
    send_request(3'd7, 32'h0000_0000, 1'b0, 8'h00, 8'h00, 9'd0);
  endtask

  task automatic test_alloc_and_match();
    send_request(CMD_ALLOC, 32'hFF10_2030, 1'b0, 8'hFF, 8'h00, 9'd0);
    send_request(CMD_ALLOC, 32'h0000_0000, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_ALLOC, 32'hFF10_2030, 1'b0, 8'h11, 8'h00, 9'd0);
    send_request(CMD_ALLOC, 32'h1234_5678, 1'b1, 8'h22, 8'h00, 9'd0);
    send_request(CMD_FIND, 32'h1234_5678, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_FIND, 32'h0010_2030, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_NEAREST, 32'h0010_2030, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_ALLOC, 32'hAA00_0000, 1'b0, 8'h33, 8'h00, 9'd0);
    // equal distance to two entries: lowest index wins
    send_request(CMD_NEAREST, 32'h5501_0101, 1'b0, 8'h00, 8'h00, 9'd0);
  endtask

  task automatic test_set_and_resize();
    send_request(CMD_SET, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'hFF, 9'd0);
    send_request(CMD_FIND, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_RESIZE, 32'h0, 1'b0, 8'h00, 8'h00, 9'd256);
    send_request(CMD_RESIZE, 32'h0, 1'b0, 8'h00, 8'h00, 9'd2);
    send_request(CMD_RESIZE, 32'h0, 1'b0, 8'h00, 8'h00, 9'd5);
    send_request(CMD_ALLOC, 32'h0000_FF00, 1'b0, 8'h44, 8'h00, 9'd0);
  endtask

  task automatic test_size_limits();
    write_max_size(9'd0);
    send_request(CMD_SET, 32'h0101_0101, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_RESIZE, 32'h0, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_ALLOC, 32'h0202_0202, 1'b0, 8'h00, 8'h00, 9'd0);
    write_max_size(9'd1);
    send_request(CMD_ALLOC, 32'h0303_0303, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_ALLOC, 32'h0404_0404, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_SET, 32'h0505_0505, 1'b0, 8'h00, 8'h01, 9'd0);
    write_max_size(9'd300);
    send_request(CMD_SET, 32'hFEDC_BA98, 1'b0, 8'h00, 8'hFF, 9'd0);
    // entries above a lowered limit still match
    write_max_size(9'd4);
    send_request(CMD_FIND, 32'hFEDC_BA98, 1'b0, 8'h00, 8'h00, 9'd0);
    send_request(CMD_RESIZE, 32'h0, 1'b0, 8'h00, 8'h00, 9'd5);
  endtask

  task automatic test_backpressure();
    wait_palette_idle();
    hold_req = 1'b1;
    repeat (10) random_request();
  endtask

  task automatic test_random();
    logic [8:0] limits [10];
    int p;
    limits = '{9'd256, 9'd8, 9'd1, 9'd64, 9'd511, 9'd3, 9'd0, 9'd32, 9'd256, 9'd16};
    for (p = 0; p < 10; p++) begin
      write_max_size(limits[p]);
      repeat (130) random_request();
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < DEPTH; i++) begin
      pal_color[i] = '0;
      pal_state[i] = ST_FREE;
    end
    for (i = 0; i < 16; i++) color_pool[i] = $urandom;
    pool_wr = 0;
    pal_size = 0;
    pal_max = 9'd256;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_palette();
    test_alloc_and_match();
    test_set_and_resize();
    test_size_limits();
    test_backpressure();
    test_random();

    wait_palette_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
